>>> hdl/amdfs_pkg.sv
package amdfs_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int RESULT_CAP = 16;
   localparam int CNT_W = $clog2(RESULT_CAP + 1);

   localparam int CMD_W = 2;
   localparam int VERTEX_W = 4;
   localparam int VCOUNT_W = 5;
   localparam int VCOUNT_RESET = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] visited_vertex;
      logic any_visited;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> hdl/amdfs_csr.sv
module amdfs_csr #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [amdfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [amdfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [amdfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output logic [$clog2(MAX_VERTICES+1)-1:0] used
);
   import amdfs_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;
   logic [CW-1:0] used_ff, used_in;
   logic reg_sel;
   logic wr_hit;

   function automatic logic [CW-1:0] clamp_count(input logic [VCOUNT_W-1:0] v);
      if (v == '0) begin
         return CW'(1);
      end else if (int'(v) > MAX_VERTICES) begin
         return CW'(MAX_VERTICES);
      end else begin
         return CW'(v);
      end
   endfunction

   assign reg_sel = csr_paddr[2] == REG_VERTEX_COUNT;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && reg_sel;
   assign vcount_in = wr_hit ? csr_pwdata[VCOUNT_W-1:0] : vcount_ff;
   assign used_in = wr_hit ? clamp_count(csr_pwdata[VCOUNT_W-1:0]) : used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_W'(VCOUNT_RESET);
         used_ff <= clamp_count(VCOUNT_W'(VCOUNT_RESET));
      end else begin
         vcount_ff <= vcount_in;
         used_ff <= used_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(vcount_ff) : '0;
   assign used = used_ff;

endmodule

>>> hdl/amdfs_adj_mem.sv
module amdfs_adj_mem #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input amdfs_pkg::mem_ctl_type ctl,
   input logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input logic [MAX_VERTICES-1:0] wr_data,
   output logic [MAX_VERTICES-1:0] rd_data
);
   import amdfs_pkg::*;

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic rd_valid_ff;

   // rows never written since reset read as zero
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/amdfs_stack_mem.sv
module amdfs_stack_mem #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input amdfs_pkg::mem_ctl_type ctl,
   input logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input logic [$clog2(MAX_VERTICES)-1:0] wr_data,
   output logic [$clog2(MAX_VERTICES)-1:0] rd_data
);
   import amdfs_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   logic [VW-1:0] mem [MAX_VERTICES];
   logic [VW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/amdfs_walk.sv
module amdfs_walk #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input amdfs_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output amdfs_pkg::rsp_type rsp_data,
   input logic [$clog2(MAX_VERTICES+1)-1:0] used,
   output amdfs_pkg::mem_ctl_type adj_ctl,
   output logic [$clog2(MAX_VERTICES)-1:0] adj_rd_addr,
   output logic [$clog2(MAX_VERTICES)-1:0] adj_wr_addr,
   output logic [MAX_VERTICES-1:0] adj_wr_data,
   input logic [MAX_VERTICES-1:0] adj_rd_data,
   output amdfs_pkg::mem_ctl_type stk_ctl,
   output logic [$clog2(MAX_VERTICES)-1:0] stk_rd_addr,
   output logic [$clog2(MAX_VERTICES)-1:0] stk_wr_addr,
   output logic [$clog2(MAX_VERTICES)-1:0] stk_wr_data,
   input logic [$clog2(MAX_VERTICES)-1:0] stk_rd_data
);
   import amdfs_pkg::*;

   localparam int V = MAX_VERTICES;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [V-1:0] ONE = V'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_RD_A,
      ST_EDGE_WR_A,
      ST_EDGE_RD_B,
      ST_EDGE_WR_B,
      ST_SCAN,
      ST_SCAN_END,
      ST_ROW,
      ST_POP,
      ST_FINAL
   } state_type;

   state_type state_ff, state_in;
   logic set_ff, set_in;
   logic [VW-1:0] va_ff, va_in;
   logic [VW-1:0] vb_ff, vb_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic scan_vld_ff, scan_vld_in;
   logic any_ff, any_in;
   logic [V-1:0] cm_ff, cm_in;
   logic [V-1:0] visited_ff, visited_in;
   logic [VW-1:0] held_ff, held_in;
   logic held_any_ff, held_any_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic out_free;
   logic any_acc;
   logic [V-1:0] used_mask;
   logic [V-1:0] cand;
   logic found;
   logic [VW-1:0] nxt;
   logic below_cap;

   always_comb begin
      for (int k = 0; k < V; k++) begin
         used_mask[k] = k < int'(used);
      end
   end

   assign cand = adj_rd_data & cm_ff & ~visited_ff;
   assign found = |cand;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign any_acc = any_ff || (scan_vld_ff && (|(adj_rd_data & cm_ff)));
   assign below_cap = cnt_ff < CNT_W'(RESULT_CAP);

   // lowest unvisited neighbor; lower columns are all done already
   always_comb begin
      nxt = '0;
      for (int k = V - 1; k >= 0; k--) begin
         if (cand[k]) begin
            nxt = VW'(k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      set_in = set_ff;
      va_in = va_ff;
      vb_in = vb_ff;
      scan_in = scan_ff;
      scan_vld_in = scan_vld_ff;
      any_in = any_ff;
      cm_in = cm_ff;
      visited_in = visited_ff;
      held_in = held_ff;
      held_any_in = held_any_ff;
      cnt_in = cnt_ff;
      depth_in = depth_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      adj_ctl = '0;
      adj_rd_addr = va_ff;
      adj_wr_addr = va_ff;
      adj_wr_data = '0;
      stk_ctl = '0;
      stk_rd_addr = '0;
      stk_wr_addr = '0;
      stk_wr_data = va_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               va_in = VW'(req_data.vertex_a);
               vb_in = VW'(req_data.vertex_b);
               set_in = req_data.cmd == CMD_SET;
               case (req_data.cmd)
                  CMD_SET, CMD_CLEAR: begin
                     if (int'(req_data.vertex_a) < V && int'(req_data.vertex_b) < V) begin
                        state_in = ST_EDGE_RD_A;
                     end
                  end
                  CMD_RUN: begin
                     cm_in = used_mask;
                     visited_in = '0;
                     depth_in = '0;
                     scan_in = '0;
                     scan_vld_in = 1'b0;
                     any_in = 1'b0;
                     if (int'(req_data.vertex_a) < int'(used)) begin
                        state_in = ST_SCAN;
                     end else begin
                        held_in = '0;
                        held_any_in = 1'b0;
                        state_in = ST_FINAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE_RD_A: begin
            adj_ctl.rd_en = 1'b1;
            adj_rd_addr = va_ff;
            state_in = ST_EDGE_WR_A;
         end
         ST_EDGE_WR_A: begin
            adj_ctl.wr_en = 1'b1;
            adj_wr_addr = va_ff;
            adj_wr_data = set_ff ? (adj_rd_data | (ONE << vb_ff))
                                 : (adj_rd_data & ~(ONE << vb_ff));
            state_in = ST_EDGE_RD_B;
         end
         ST_EDGE_RD_B: begin
            adj_ctl.rd_en = 1'b1;
            adj_rd_addr = vb_ff;
            state_in = ST_EDGE_WR_B;
         end
         ST_EDGE_WR_B: begin
            adj_ctl.wr_en = 1'b1;
            adj_wr_addr = vb_ff;
            adj_wr_data = set_ff ? (adj_rd_data | (ONE << va_ff))
                                 : (adj_rd_data & ~(ONE << va_ff));
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            adj_ctl.rd_en = 1'b1;
            adj_rd_addr = scan_ff[VW-1:0];
            scan_in = scan_ff + CW'(1);
            scan_vld_in = 1'b1;
            any_in = any_acc;
            if (scan_ff == used - CW'(1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (any_acc) begin
               visited_in = ONE << va_ff;
               held_in = va_ff;
               held_any_in = 1'b1;
               cnt_in = CNT_W'(1);
               depth_in = CW'(1);
               stk_ctl.wr_en = 1'b1;
               stk_wr_addr = '0;
               stk_wr_data = va_ff;
               adj_ctl.rd_en = 1'b1;
               adj_rd_addr = va_ff;
               state_in = ST_ROW;
            end else begin
               held_in = '0;
               held_any_in = 1'b0;
               state_in = ST_FINAL;
            end
         end
         ST_ROW: begin
            if (found) begin
               if (!below_cap || out_free) begin
                  if (below_cap) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.visited_vertex = VERTEX_W'(held_ff);
                     rsp_data_in.any_visited = held_any_ff;
                     rsp_data_in.last = 1'b0;
                     held_in = nxt;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
                  visited_in = visited_ff | (ONE << nxt);
                  stk_ctl.wr_en = 1'b1;
                  stk_wr_addr = depth_ff[VW-1:0];
                  stk_wr_data = nxt;
                  depth_in = depth_ff + CW'(1);
                  adj_ctl.rd_en = 1'b1;
                  adj_rd_addr = nxt;
               end
            end else begin
               depth_in = depth_ff - CW'(1);
               if (depth_ff == CW'(1)) begin
                  state_in = ST_FINAL;
               end else begin
                  stk_ctl.rd_en = 1'b1;
                  stk_rd_addr = VW'(depth_ff - CW'(2));
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            adj_ctl.rd_en = 1'b1;
            adj_rd_addr = stk_rd_data;
            state_in = ST_ROW;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.visited_vertex = VERTEX_W'(held_ff);
               rsp_data_in.any_visited = held_any_ff;
               rsp_data_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff <= '0;
         cnt_ff <= '0;
         scan_vld_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff <= depth_in;
         cnt_ff <= cnt_in;
         scan_vld_ff <= scan_vld_in;
         any_ff <= any_in;
      end
      set_ff <= set_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
      scan_ff <= scan_in;
      cm_ff <= cm_in;
      visited_ff <= visited_in;
      held_ff <= held_in;
      held_any_ff <= held_any_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) depth_ff <= used)
      else $error("walk stack deeper than vertex count");

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(RESULT_CAP))
      else $error("result count beyond cap");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW || state_ff == ST_POP) |-> depth_ff != '0)
      else $error("row scan with empty stack");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && out_free) |=> rsp_valid_ff && rsp_data_ff.last)
      else $error("final transaction not flagged last");

endmodule

>>> hdl/adjacency_matrix_dfs.sv
// Channel  Direction  Payload                             Handshake
// req      in         cmd, vertex_a, vertex_b             req_valid / req_stall
// rsp      out        visited_vertex, any_visited, last   rsp_valid / rsp_stall
// csr      in/out     vertex_count at byte address 0      APB, pready tied high
//
// Set/clear edge: read-modify-write of row A, then of row B (separate states).
// Run: an edge scan of the N used rows, then the walk: a row read per push,
// and a stack read plus a row read per pop.
// Reset: synchronous; adjacency rows read as zero through per-row valid bits.
// rsp is registered; a stalled result holds and the walk waits for the slot.
module adjacency_matrix_dfs #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input amdfs_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output amdfs_pkg::rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [amdfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [amdfs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [amdfs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import amdfs_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [CW-1:0] used;
   mem_ctl_type adj_ctl;
   logic [VW-1:0] adj_rd_addr;
   logic [VW-1:0] adj_wr_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data;
   logic [MAX_VERTICES-1:0] adj_rd_data;
   mem_ctl_type stk_ctl;
   logic [VW-1:0] stk_rd_addr;
   logic [VW-1:0] stk_wr_addr;
   logic [VW-1:0] stk_wr_data;
   logic [VW-1:0] stk_rd_data;

   amdfs_csr #(.MAX_VERTICES(MAX_VERTICES)) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .used(used)
   );

   amdfs_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj_mem (
      .clock(clock),
      .reset(reset),
      .ctl(adj_ctl),
      .rd_addr(adj_rd_addr),
      .wr_addr(adj_wr_addr),
      .wr_data(adj_wr_data),
      .rd_data(adj_rd_data)
   );

   amdfs_stack_mem #(.MAX_VERTICES(MAX_VERTICES)) u_stack_mem (
      .clock(clock),
      .ctl(stk_ctl),
      .rd_addr(stk_rd_addr),
      .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data),
      .rd_data(stk_rd_data)
   );

   amdfs_walk #(.MAX_VERTICES(MAX_VERTICES)) u_walk (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .used(used),
      .adj_ctl(adj_ctl),
      .adj_rd_addr(adj_rd_addr),
      .adj_wr_addr(adj_wr_addr),
      .adj_wr_data(adj_wr_data),
      .adj_rd_data(adj_rd_data),
      .stk_ctl(stk_ctl),
      .stk_rd_addr(stk_rd_addr),
      .stk_wr_addr(stk_wr_addr),
      .stk_wr_data(stk_wr_data),
      .stk_rd_data(stk_rd_data)
   );

endmodule
